[rtl/lrud_pkg.sv]
// ----------------------------------------------------------------------------
// lrud_pkg
// Shared types and constants of the set-associative LRU cache directory.
// ----------------------------------------------------------------------------
package lrud_pkg;

  localparam int LINES     = 256;
  localparam int LINE_AW   = $clog2(LINES);
  localparam int ADDR_W    = 16;
  localparam int TAG_W     = 16;
  localparam int AGE_W     = 8;
  localparam int CNT_W     = 9;
  localparam int KIND_W    = 3;
  localparam int PADDR_W   = 4;
  localparam int MAX_OFF   = 8;
  localparam int MAX_IDX   = 8;
  localparam int MAX_WAYS  = 256;

  localparam logic [KIND_W-1:0] KIND_CACHE_TO_CPU = 3'd0;
  localparam logic [KIND_W-1:0] KIND_CPU_TO_CACHE = 3'd1;
  localparam logic [KIND_W-1:0] KIND_MEM_TO_CACHE = 3'd2;
  localparam logic [KIND_W-1:0] KIND_CACHE_TO_MEM = 3'd3;
  localparam logic [KIND_W-1:0] KIND_DROPPED      = 3'd4;

  localparam logic [PADDR_W-1:0] REG_OFFSET_BITS = 4'd0;
  localparam logic [PADDR_W-1:0] REG_INDEX_BITS  = 4'd4;
  localparam logic [PADDR_W-1:0] REG_WAYS        = 4'd8;

  typedef struct packed {
    logic [TAG_W-1:0] tag;
    logic             valid;
    logic             dirty;
    logic [AGE_W-1:0] age;
  } line_t;

  localparam int LINE_BITS = $bits(line_t);

  typedef struct packed {
    logic [3:0]       off;
    logic [3:0]       idx;
    logic [CNT_W-1:0] nw;
  } cfg_t;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [ADDR_W-1:0] start;
    logic [CNT_W-1:0]  count;
    logic              last;
    logic              hit;
  } rec_t;

endpackage

[rtl/lrud_ifs.sv]
// ----------------------------------------------------------------------------
// lrud_ifs
// Valid/ready channels: access request and transfer record.
// ----------------------------------------------------------------------------
interface lrud_req_if;
  logic        valid;
  logic        ready;
  logic [15:0] addr;
  logic        is_write;
  modport source (output valid, addr, is_write, input ready);
  modport sink (input valid, addr, is_write, output ready);
endinterface

interface lrud_rsp_if;
  logic        valid;
  logic        ready;
  logic [2:0]  transfer_kind;
  logic [15:0] start_addr;
  logic [8:0]  word_count;
  logic        last_of_access;
  logic        was_hit;
  logic [8:0]  dirty_lines;
  modport source (output valid, transfer_kind, start_addr, word_count, last_of_access,
                  was_hit, dirty_lines, input ready);
  modport sink (input valid, transfer_kind, start_addr, word_count, last_of_access,
                was_hit, dirty_lines, output ready);
endinterface

[rtl/lrud_ram.sv]
// ----------------------------------------------------------------------------
// lrud_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module lrud_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[rtl/lrud_cfg.sv]
// ----------------------------------------------------------------------------
// lrud_cfg
// APB register file; delivers clamped geometry.
// ----------------------------------------------------------------------------
module lrud_cfg
  import lrud_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  output cfg_t               cfg
);

  logic [3:0]       offset_bits;
  logic [3:0]       index_bits;
  logic [CNT_W-1:0] ways;
  logic             wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      offset_bits <= 4'd0;
      index_bits  <= 4'd0;
      ways        <= CNT_W'(1);
    end else if (wr_en) begin
      case (paddr)
        REG_OFFSET_BITS: offset_bits <= pwdata[3:0];
        REG_INDEX_BITS:  index_bits  <= pwdata[3:0];
        REG_WAYS:        ways        <= pwdata[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr)
      REG_OFFSET_BITS: prdata = {28'd0, offset_bits};
      REG_INDEX_BITS:  prdata = {28'd0, index_bits};
      REG_WAYS:        prdata = {{(32-CNT_W){1'b0}}, ways};
      default:         prdata = 32'd0;
    endcase
  end

  always_comb begin
    cfg.off = (offset_bits > 4'(MAX_OFF)) ? 4'(MAX_OFF) : offset_bits;
    cfg.idx = (index_bits > 4'(MAX_IDX)) ? 4'(MAX_IDX) : index_bits;
    if (ways == '0) begin
      cfg.nw = CNT_W'(1);
    end else if (ways > CNT_W'(MAX_WAYS)) begin
      cfg.nw = CNT_W'(MAX_WAYS);
    end else begin
      cfg.nw = ways;
    end
  end

endmodule

[rtl/set_assoc_lru_cache_directory_core.sv]
// ----------------------------------------------------------------------------
// set_assoc_lru_cache_directory_core
// Write-back, write-allocate LRU cache directory; emits the transfer trace.
// ----------------------------------------------------------------------------
// channel  dir  handshake       word
// req      in   valid/ready     addr, is_write
// rsp      out  valid/ready     transfer_kind, start_addr, word_count, ...
// apb      in   psel/penable    offset_bits, index_bits, ways
//
// An access reads the set once through the line RAM read port to look up,
// then reads it again and rewrites it one line a cycle to age it, and then
// emits its records. After reset a clear pass zeroes all 256 lines before
// the first request is taken. Records are held while rsp stalls.
// ----------------------------------------------------------------------------
module set_assoc_lru_cache_directory_core
  import lrud_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  lrud_req_if.sink           req,
  lrud_rsp_if.source         rsp,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  typedef enum logic [4:0] {
    ST_CLEAR  = 5'b00001,
    ST_IDLE   = 5'b00010,
    ST_SCAN   = 5'b00100,
    ST_UPDATE = 5'b01000,
    ST_EMIT   = 5'b10000
  } state_t;

  state_t state;
  cfg_t   cfg;

  lrud_cfg u_cfg (
    .clk, .rst, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready, .cfg
  );

  // access context
  logic [ADDR_W-1:0]  a_addr;
  logic               a_wr;
  logic [3:0]         a_off;
  logic [3:0]         a_idx;
  logic [CNT_W-1:0]   a_nw;
  logic [LINE_AW-1:0] a_set;
  logic [TAG_W-1:0]   a_tag;
  logic [LINE_AW-1:0] a_base;

  logic [LINE_AW-1:0] set_c;
  logic [16:0]        prod_c;

  // RAM pass
  logic [CNT_W-1:0]   rd_w;
  logic               pv;
  logic [LINE_AW-1:0] pw;
  logic               issue;
  logic               pass_end;
  logic [LINE_AW-1:0] clr_cnt;

  logic               ram_we;
  logic [LINE_AW-1:0] ram_waddr;
  line_t              ram_wdata;
  logic [LINE_AW-1:0] ram_raddr;
  logic [LINE_BITS-1:0] ram_rdata;
  line_t              e;
  logic [LINE_AW-1:0] cur_line;

  // lookup results
  logic               hit;
  logic [LINE_AW-1:0] hit_line;
  logic [AGE_W-1:0]   hit_age;
  logic               inv_found;
  logic [LINE_AW-1:0] inv_line;
  logic               has_best;
  logic [AGE_W-1:0]   best_age;
  logic [LINE_AW-1:0] best_line;
  logic [TAG_W-1:0]   best_tag;
  logic               best_dirty;
  logic [LINE_AW-1:0] tgt;

  logic [CNT_W-1:0]   dirty_total;
  logic [CNT_W-1:0]   dirty_next;
  rec_t               res [3];
  logic [1:0]         res_n;
  logic [1:0]         k;

  logic [CNT_W-1:0]   blk;
  logic [ADDR_W-1:0]  vaddr;
  logic [ADDR_W-1:0]  fill_addr;
  logic               evict;
  logic [KIND_W-1:0]  cpu_kind;

  assign set_c  = LINE_AW'((req.addr >> cfg.off) & ((ADDR_W'(1) << cfg.idx) - ADDR_W'(1)));
  assign prod_c = 17'(set_c) * 17'(cfg.nw);

  assign req.ready = (state == ST_IDLE);
  assign issue     = (rd_w < a_nw);
  assign pass_end  = pv && (9'(pw) == a_nw - CNT_W'(1));
  assign e         = line_t'(ram_rdata);
  assign cur_line  = a_base + pw;
  assign ram_raddr = a_base + rd_w[LINE_AW-1:0];

  assign tgt   = hit ? hit_line : (inv_found ? inv_line : best_line);
  assign evict = !hit && !inv_found;

  lrud_ram #(.WIDTH(LINE_BITS), .DEPTH(LINES)) u_lines (
    .clk, .we(ram_we), .waddr(ram_waddr), .wdata(ram_wdata),
    .raddr(ram_raddr), .rdata(ram_rdata)
  );

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = cur_line;
    ram_wdata = e;
    if (state == ST_CLEAR) begin
      ram_we    = 1'b1;
      ram_waddr = clr_cnt;
      ram_wdata = '0;
    end else if (state == ST_UPDATE && pv) begin
      ram_we = 1'b1;
      if (cur_line == tgt) begin
        ram_wdata.age = '0;
        if (hit) begin
          ram_wdata.dirty = e.dirty | a_wr;
        end else begin
          ram_wdata.tag   = a_tag;
          ram_wdata.valid = 1'b1;
          ram_wdata.dirty = a_wr;
        end
      end else if (hit) begin
        if (e.age < hit_age) ram_wdata.age = e.age + AGE_W'(1);
      end else begin
        if (e.age != '1) ram_wdata.age = e.age + AGE_W'(1);
      end
    end
  end

  always_comb begin
    blk       = CNT_W'(1) << a_off;
    vaddr     = ADDR_W'((best_tag << (5'(a_off) + 5'(a_idx))) | (ADDR_W'(a_set) << a_off));
    fill_addr = a_addr & ~(ADDR_W'(blk) - ADDR_W'(1));
    cpu_kind  = a_wr ? KIND_CPU_TO_CACHE : KIND_CACHE_TO_CPU;
    dirty_next = dirty_total;
    if (hit) begin
      if (a_wr && !best_dirty) dirty_next = dirty_total + CNT_W'(1);
    end else begin
      dirty_next = dirty_total - CNT_W'(evict && best_dirty) + CNT_W'(a_wr);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_CLEAR;
      clr_cnt     <= '0;
      rd_w        <= '0;
      pv          <= 1'b0;
      k           <= '0;
      dirty_total <= '0;
    end else begin
      case (state)
        ST_CLEAR: begin
          clr_cnt <= clr_cnt + LINE_AW'(1);
          if (clr_cnt == '1) state <= ST_IDLE;
        end
        ST_IDLE: begin
          if (req.valid) begin
            state <= ST_SCAN;
            rd_w  <= '0;
            pv    <= 1'b0;
          end
        end
        ST_SCAN, ST_UPDATE: begin
          pv   <= issue;
          pw   <= rd_w[LINE_AW-1:0];
          rd_w <= rd_w + CNT_W'(issue);
          if (pass_end) begin
            rd_w <= '0;
            pv   <= 1'b0;
            if (state == ST_SCAN) begin
              state <= ST_UPDATE;
            end else begin
              state       <= ST_EMIT;
              k           <= '0;
              dirty_total <= dirty_next;
            end
          end
        end
        ST_EMIT: begin
          if (rsp.ready) begin
            k <= k + 2'd1;
            if (k == res_n - 2'd1) state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_IDLE && req.valid) begin
      a_addr     <= req.addr;
      a_wr       <= req.is_write;
      a_off      <= cfg.off;
      a_idx      <= cfg.idx;
      a_nw       <= cfg.nw;
      a_set      <= set_c;
      a_tag      <= TAG_W'(req.addr >> (5'(cfg.off) + 5'(cfg.idx)));
      a_base     <= prod_c[LINE_AW-1:0];
      hit        <= 1'b0;
      inv_found  <= 1'b0;
      has_best   <= 1'b0;
    end
    if (state == ST_SCAN && pv) begin
      if (!hit && e.valid && e.tag == a_tag) begin
        hit        <= 1'b1;
        hit_line   <= cur_line;
        hit_age    <= e.age;
        best_dirty <= e.dirty;
      end else if (!hit && (!has_best || e.age > best_age)) begin
        has_best   <= 1'b1;
        best_age   <= e.age;
        best_line  <= cur_line;
        best_tag   <= e.tag;
        best_dirty <= e.dirty;
      end
      if (!inv_found && !e.valid) begin
        inv_found <= 1'b1;
        inv_line  <= cur_line;
      end
    end
    if (state == ST_UPDATE && pass_end) begin
      if (hit) begin
        res[0] <= '{cpu_kind, a_addr, CNT_W'(1), 1'b1, 1'b1};
        res[1] <= '{cpu_kind, a_addr, CNT_W'(1), 1'b1, 1'b1};
        res[2] <= '{cpu_kind, a_addr, CNT_W'(1), 1'b1, 1'b1};
        res_n  <= 2'd1;
      end else if (evict) begin
        res[0] <= '{best_dirty ? KIND_CACHE_TO_MEM : KIND_DROPPED, vaddr, blk, 1'b0, 1'b0};
        res[1] <= '{KIND_MEM_TO_CACHE, fill_addr, blk, 1'b0, 1'b0};
        res[2] <= '{cpu_kind, a_addr, CNT_W'(1), 1'b1, 1'b0};
        res_n  <= 2'd3;
      end else begin
        res[0] <= '{KIND_MEM_TO_CACHE, fill_addr, blk, 1'b0, 1'b0};
        res[1] <= '{cpu_kind, a_addr, CNT_W'(1), 1'b1, 1'b0};
        res[2] <= '{cpu_kind, a_addr, CNT_W'(1), 1'b1, 1'b0};
        res_n  <= 2'd2;
      end
    end
  end

  assign rsp.valid          = (state == ST_EMIT);
  assign rsp.transfer_kind  = res[k].kind;
  assign rsp.start_addr     = res[k].start;
  assign rsp.word_count     = res[k].count;
  assign rsp.last_of_access = res[k].last;
  assign rsp.was_hit        = res[k].hit;
  assign rsp.dirty_lines    = dirty_total;

  a_dirty_bound: assert property (@(posedge clk) disable iff (rst)
    dirty_total <= CNT_W'(LINES))
    else $error("dirty count above line count");

  a_emit_hold: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && !rsp.ready |=> $stable(k) && rsp.valid)
    else $error("record index moved while stalled");

  a_pass_range: assert property (@(posedge clk) disable iff (rst)
    pv |-> (9'(pw) < a_nw))
    else $error("line pass beyond set");

  a_no_ready_busy: assert property (@(posedge clk) disable iff (rst)
    rsp.valid |-> !req.ready)
    else $error("request taken while records pending");

endmodule
